>>> hdl/lqh_pkg.sv
// Shared types and constants of the link quality hysteresis block.
package lqh_pkg;

    localparam int INDEX_W       = 6;
    localparam int LINKS_DEFAULT = 64;
    localparam int Q_W           = 17;
    localparam int SEQ_W         = 16;
    localparam int TIME_W        = 32;
    localparam int VERDICT_W     = 2;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALING        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME      = 2'd3;

    localparam logic [Q_W-1:0]    SCALING_RESET        = 17'd32768;
    localparam logic [Q_W-1:0]    THRESHOLD_HIGH_RESET = 17'd52429;
    localparam logic [Q_W-1:0]    THRESHOLD_LOW_RESET  = 17'd19661;
    localparam logic [TIME_W-1:0] HOLD_TIME_RESET      = 32'd6000;

    localparam logic [Q_W-1:0]    ONE_Q16         = 17'h10000;
    localparam logic [Q_W-1:0]    HALF_Q16        = 17'h08000;
    localparam logic [TIME_W-1:0] LOST_BACKOFF_MS = 32'd1000;

    localparam logic [VERDICT_W-1:0] VERDICT_ABOVE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BAND  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BELOW = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PACKET,
        OP_EVAL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] link_index;
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  now_ms;
        logic [TIME_W-1:0]  expiry_ms;
    } cmd_t;

endpackage

>>> hdl/lqh_front.sv
// Front end: accepts input transfers, classifies them and pushes commands.
module lqh_front #(
    parameter int LINKS = lqh_pkg::LINKS_DEFAULT
) (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [lqh_pkg::INDEX_W-1:0] link_index,
    input  logic [lqh_pkg::SEQ_W-1:0]   sequence_number,
    input  logic [lqh_pkg::TIME_W-1:0]  now_ms,
    input  logic [lqh_pkg::TIME_W-1:0]  link_expiry_ms,
    input  logic                        q_full,
    output logic                        push,
    output lqh_pkg::cmd_t               push_data
);

    logic in_range;

    assign in_range = 32'(link_index) < 32'(LINKS);
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_data.link_index = link_index;
        push_data.seq        = sequence_number;
        push_data.now_ms     = now_ms;
        push_data.expiry_ms  = link_expiry_ms;
        // out-of-range links touch nothing in the table
        if (!in_range)
        begin
            push_data.op = lqh_pkg::OP_NONE;
        end
        else if (kind)
        begin
            push_data.op = lqh_pkg::OP_EVAL;
        end
        else
        begin
            push_data.op = lqh_pkg::OP_PACKET;
        end
    end

endmodule

>>> hdl/lqh_queue.sv
// Short command queue between the front and back ends.
module lqh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lqh_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output lqh_pkg::cmd_t head,
    output logic          empty
);

    lqh_pkg::cmd_t                    slot_reg [lqh_pkg::QDEPTH];
    logic [lqh_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [lqh_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [lqh_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [lqh_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [lqh_pkg::QCNT_W-1:0]       count_reg;
    logic [lqh_pkg::QCNT_W-1:0]       count_next;

    assign full  = count_reg == lqh_pkg::QCNT_W'(lqh_pkg::QDEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == lqh_pkg::QPTR_W'(lqh_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + lqh_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lqh_pkg::QPTR_W'(lqh_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + lqh_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + lqh_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lqh_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/lqh_back.sv
// Back end: link table, quality update, threshold evaluation and result register.
module lqh_back #(
    parameter int LINKS = lqh_pkg::LINKS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  lqh_pkg::cmd_t                 q_head,
    output logic                          q_pop,
    input  logic [lqh_pkg::Q_W-1:0]       scaling,
    input  logic [lqh_pkg::Q_W-1:0]       threshold_high,
    input  logic [lqh_pkg::Q_W-1:0]       threshold_low,
    input  logic [lqh_pkg::TIME_W-1:0]    hold_time_ms,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lqh_pkg::VERDICT_W-1:0] verdict,
    output logic [lqh_pkg::Q_W-1:0]       quality_out,
    output logic                          pending_out,
    output logic                          neighborhood_changed,
    output logic [lqh_pkg::TIME_W-1:0]    lost_deadline_out
);

    // only indexes the input field can name need storage
    localparam int DEPTH = (LINKS < (1 << lqh_pkg::INDEX_W)) ? LINKS : (1 << lqh_pkg::INDEX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * lqh_pkg::Q_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [lqh_pkg::Q_W-1:0]    quality;
        logic                       pending;
        logic [lqh_pkg::SEQ_W-1:0]  seq;
        logic [lqh_pkg::TIME_W-1:0] deadline;
    } entry_t;

    entry_t                         mem [DEPTH];
    logic [DEPTH-1:0]               valid_reg;
    entry_t                         rd_entry_reg;
    logic                           rd_valid_reg;

    state_t                         state_reg;
    lqh_pkg::cmd_t                  cmd_reg;
    entry_t                         ent_reg;
    logic [lqh_pkg::Q_W-1:0]        q1_reg;
    logic                           loss_reg;
    logic                           above_reg;
    logic                           below_reg;
    logic                           lapsed_reg;
    logic [lqh_pkg::TIME_W-1:0]     dl_above_reg;
    logic [lqh_pkg::TIME_W-1:0]     limit_reg;

    logic                           out_valid_reg;
    logic [lqh_pkg::VERDICT_W-1:0]  verdict_reg;
    logic [lqh_pkg::Q_W-1:0]        quality_reg;
    logic                           pending_reg;
    logic                           changed_reg;
    logic [lqh_pkg::TIME_W-1:0]     deadline_reg;

    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic                           can_load;

    entry_t                         cur;
    logic [lqh_pkg::Q_W-1:0]        s_w;
    logic [lqh_pkg::Q_W-1:0]        inv_w;
    logic [PW-1:0]                  raise_sum;
    logic [lqh_pkg::Q_W-1:0]        q1;
    logic [lqh_pkg::SEQ_W:0]        last_p1;
    logic                           loss;
    logic [lqh_pkg::TIME_W:0]       hold_sum;
    logic [lqh_pkg::TIME_W-1:0]     limit;
    logic [lqh_pkg::TIME_W-1:0]     dl_above;

    logic [PW-1:0]                  lower_sum;
    logic [lqh_pkg::Q_W-1:0]        q2;
    entry_t                         nxt;
    logic [lqh_pkg::VERDICT_W-1:0]  verdict_c;
    logic                           changed_c;
    logic                           write_c;

    assign busy     = state_reg != ST_IDLE;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign rd_en    = q_pop && (q_head.op != lqh_pkg::OP_NONE);
    assign rd_addr  = q_head.link_index[AW-1:0];
    assign wr_addr  = cmd_reg.link_index[AW-1:0];
    assign can_load = !out_valid_reg || !out_stall;
    assign wr_en    = (state_reg == ST_DONE) && can_load && write_c;

    // weight of a new observation, clamped to one
    assign s_w   = (scaling > lqh_pkg::ONE_Q16) ? lqh_pkg::ONE_Q16 : scaling;
    assign inv_w = lqh_pkg::ONE_Q16 - s_w;

    // read stage result: an entry never written reads as zero
    assign cur = rd_valid_reg ? rd_entry_reg : '0;

    always_comb
    begin
        raise_sum = PW'(inv_w) * PW'(cur.quality) + PW'({s_w, 16'h0000})
                  + PW'(lqh_pkg::HALF_Q16);
        q1        = raise_sum[lqh_pkg::Q_W+15:16];
        last_p1   = {1'b0, cur.seq} + 17'd1;
        loss      = (last_p1 < {1'b0, cmd_reg.seq}) && (cur.seq != '0)
                 && (cmd_reg.seq != '0);
        hold_sum  = {1'b0, cmd_reg.now_ms} + {1'b0, hold_time_ms};
        limit     = hold_sum[lqh_pkg::TIME_W] ? '1 : hold_sum[lqh_pkg::TIME_W-1:0];
        dl_above  = (cmd_reg.now_ms >= lqh_pkg::LOST_BACKOFF_MS) ?
                    cmd_reg.now_ms - lqh_pkg::LOST_BACKOFF_MS : '0;
    end

    always_comb
    begin
        lower_sum = PW'(inv_w) * PW'(q1_reg) + PW'(lqh_pkg::HALF_Q16);
        q2        = lower_sum[lqh_pkg::Q_W+15:16];
        nxt       = ent_reg;
        verdict_c = lqh_pkg::VERDICT_BAND;
        changed_c = 1'b0;
        write_c   = 1'b0;
        unique case (cmd_reg.op)
            lqh_pkg::OP_PACKET:
            begin
                nxt.quality = loss_reg ? q2 : q1_reg;
                nxt.seq     = cmd_reg.seq;
                write_c     = 1'b1;
            end
            lqh_pkg::OP_EVAL:
            begin
                priority if (above_reg)
                begin
                    verdict_c    = lqh_pkg::VERDICT_ABOVE;
                    changed_c    = ent_reg.pending || !lapsed_reg;
                    nxt.pending  = 1'b0;
                    nxt.deadline = dl_above_reg;
                    write_c      = 1'b1;
                end
                else if (below_reg)
                begin
                    verdict_c    = lqh_pkg::VERDICT_BELOW;
                    changed_c    = !ent_reg.pending || lapsed_reg;
                    nxt.pending  = 1'b1;
                    nxt.deadline = (cmd_reg.expiry_ms < limit_reg) ?
                                   cmd_reg.expiry_ms : limit_reg;
                    write_c      = 1'b1;
                end
                else
                begin
                    // within the band: keep the entry as it is
                    write_c      = 1'b0;
                end
            end
            default:
            begin
                nxt = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= nxt;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            ent_reg       <= '0;
            q1_reg        <= '0;
            loss_reg      <= 1'b0;
            above_reg     <= 1'b0;
            below_reg     <= 1'b0;
            lapsed_reg    <= 1'b0;
            dl_above_reg  <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= lqh_pkg::VERDICT_BAND;
            quality_reg   <= '0;
            pending_reg   <= 1'b0;
            changed_reg   <= 1'b0;
            deadline_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= q_head;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    ent_reg       <= cur;
                    q1_reg        <= q1;
                    loss_reg      <= loss;
                    above_reg     <= cur.quality > threshold_high;
                    below_reg     <= cur.quality < threshold_low;
                    lapsed_reg    <= cur.deadline < cmd_reg.now_ms;
                    dl_above_reg  <= dl_above;
                    limit_reg     <= limit;
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    // hold until the result register frees up
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        verdict_reg   <= verdict_c;
                        quality_reg   <= nxt.quality;
                        pending_reg   <= nxt.pending;
                        changed_reg   <= changed_c;
                        deadline_reg  <= nxt.deadline;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid            = out_valid_reg;
    assign verdict              = verdict_reg;
    assign quality_out          = quality_reg;
    assign pending_out          = pending_reg;
    assign neighborhood_changed = changed_reg;
    assign lost_deadline_out    = deadline_reg;

endmodule

>>> hdl/link_quality_hysteresis.sv
// Top level of the link quality hysteresis block: configuration registers and wiring.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------------
//  input    | in_valid / in_stall | kind, link_index, sequence_number, now_ms,
//           |                     | link_expiry_ms
//  output   | out_valid/out_stall | verdict, quality_out, pending_out,
//           |                     | neighborhood_changed, lost_deadline_out
//  config   | cfg_write           | cfg_index, cfg_data
//
//  The back end handles one item at a time: table read, quality raise multiply,
//  then the loss multiply with write-back; the registered table read and the two
//  dependent multiplies make these separate steps.
//  A two-entry command queue takes new items while the back end works.
//  Reset clears the table at once through per-entry valid bits; no clearing pass.
//  in_stall rises only when the queue is full; out_stall holds the result register.
module link_quality_hysteresis #(
    parameter int LINKS = lqh_pkg::LINKS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [lqh_pkg::INDEX_W-1:0]     link_index,
    input  logic [lqh_pkg::SEQ_W-1:0]       sequence_number,
    input  logic [lqh_pkg::TIME_W-1:0]      now_ms,
    input  logic [lqh_pkg::TIME_W-1:0]      link_expiry_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lqh_pkg::VERDICT_W-1:0]   verdict,
    output logic [lqh_pkg::Q_W-1:0]         quality_out,
    output logic                            pending_out,
    output logic                            neighborhood_changed,
    output logic [lqh_pkg::TIME_W-1:0]      lost_deadline_out,
    input  logic                            cfg_write,
    input  logic [lqh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lqh_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [lqh_pkg::Q_W-1:0]    scaling_reg;
    logic [lqh_pkg::Q_W-1:0]    threshold_high_reg;
    logic [lqh_pkg::Q_W-1:0]    threshold_low_reg;
    logic [lqh_pkg::TIME_W-1:0] hold_time_reg;

    logic          push;
    lqh_pkg::cmd_t push_data;
    logic          q_full;
    logic          q_pop;
    lqh_pkg::cmd_t q_head;
    logic          q_empty;
    logic          back_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaling_reg        <= lqh_pkg::SCALING_RESET;
            threshold_high_reg <= lqh_pkg::THRESHOLD_HIGH_RESET;
            threshold_low_reg  <= lqh_pkg::THRESHOLD_LOW_RESET;
            hold_time_reg      <= lqh_pkg::HOLD_TIME_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lqh_pkg::REG_SCALING:        scaling_reg        <= cfg_data[lqh_pkg::Q_W-1:0];
                lqh_pkg::REG_THRESHOLD_HIGH: threshold_high_reg <= cfg_data[lqh_pkg::Q_W-1:0];
                lqh_pkg::REG_THRESHOLD_LOW:  threshold_low_reg  <= cfg_data[lqh_pkg::Q_W-1:0];
                lqh_pkg::REG_HOLD_TIME:      hold_time_reg      <= cfg_data;
                default:                     hold_time_reg      <= hold_time_reg;
            endcase
        end
    end

    lqh_front #(
        .LINKS(LINKS)
    ) u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .link_index      (link_index),
        .sequence_number (sequence_number),
        .now_ms          (now_ms),
        .link_expiry_ms  (link_expiry_ms),
        .q_full          (q_full),
        .push            (push),
        .push_data       (push_data)
    );

    lqh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    lqh_back #(
        .LINKS(LINKS)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_empty              (q_empty),
        .q_head               (q_head),
        .q_pop                (q_pop),
        .scaling              (scaling_reg),
        .threshold_high       (threshold_high_reg),
        .threshold_low        (threshold_low_reg),
        .hold_time_ms         (hold_time_reg),
        .busy                 (back_busy),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .verdict              (verdict),
        .quality_out          (quality_out),
        .pending_out          (pending_out),
        .neighborhood_changed (neighborhood_changed),
        .lost_deadline_out    (lost_deadline_out)
    );

`ifndef ASSERT_OFF
    // a new result only appears after the back end worked on an item
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_busy))
        else $error("result appeared without back-end work");

    // an idle back end picks up a queued command at once
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && !back_busy) |=> back_busy)
        else $error("queued command not dispatched");

    // an accepted transfer is either queued or already in the back end
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (!q_empty || back_busy))
        else $error("accepted transfer lost");
`endif

endmodule
